FILE: rtl/mbrtu_pkg.sv
// Shared types, constants and the CRC-16/MODBUS byte step for the
// read-holding-registers responder. No dependencies.
package mbrtu_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int TAB_AW      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int STORE_DEPTH = 8;
  localparam int LEN_LIMIT   = 256;
  localparam int MAX_QTY     = 125;
  localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // configuration register indexes
  localparam logic [1:0] CFG_DEV_ADDR = 2'd0;
  localparam logic [1:0] CFG_ENTRY_CNT = 2'd1;
  localparam logic [1:0] CFG_BUF_CAP = 2'd2;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_ILLEGAL_FUNC = 3'd1,
    ST_BAD_ADDR     = 3'd2,
    ST_BAD_VALUE    = 3'd3,
    ST_DEV_FAIL     = 3'd4,
    ST_CRC          = 3'd5,
    ST_ADDR_MISMATCH = 3'd6
  } stat_e;

  typedef enum logic [1:0] {
    SRC_HDR,
    SRC_SH,
    SRC_CRCLO,
    SRC_CRCHI
  } src_e;

  // controller to datapath
  typedef struct packed {
    logic  tab_wr;
    logic  rx_byte;
    logic  chk;
    logic  srch_rd;
    logic  srch_lt;
    logic  srch_gt;
    logic  srch_hit;
    logic  walk_init;
    logic  crc_init;
    logic  push;
    src_e  src;
    logic  push_final;
    logic  sink_out;
    logic  rd_ix;
    logic  rd_next;
    logic  load_sh;
    logic  step_i;
    logic  err_vld;
    stat_e err_code;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    stat_e chk_err;
    logic  srch_open;
    logic  srch_eq;
    logic  srch_lt;
    stat_e range_err;
    logic  hdr_done;
    logic  i_done;
    logic  addr_ok;
    logic  is_short;
    logic  is_long;
    logic  last_pos;
    logic  next_ok;
    logic  sh_last;
  } sts_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] x;
    x = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
    end
    return x;
  endfunction

endpackage

FILE: rtl/mbrtu_ctrl.sv
// Sequencer for the responder: frame check, table search, two-pass walk.
// Depends on mbrtu_pkg; drives mbrtu_dp through cmd_t and reads sts_t.
module mbrtu_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               command_i,
  input  logic               frame_last_i,
  input  mbrtu_pkg::sts_t    sts_i,
  output mbrtu_pkg::cmd_t    cmd_o,
  output logic               busy_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_SRD, S_SCMP, S_RANGE, S_HDR, S_WRD,
    S_WCHK, S_WCHK2, S_WBYT, S_TAIL, S_CRCHI
  } state_e;

  state_e state_q, state_d;
  logic   pass_q, pass_d;

  assign busy_o = (state_q != S_IDLE);

  // decode commands and next state
  always_comb begin
    cmd_o = '0;
    cmd_o.src = mbrtu_pkg::SRC_HDR;
    cmd_o.err_code = mbrtu_pkg::ST_OK;
    cmd_o.sink_out = pass_q;
    state_d = state_q;
    pass_d = pass_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (command_i) begin
            cmd_o.tab_wr = 1'b1;
          end else begin
            cmd_o.rx_byte = 1'b1;
            if (frame_last_i) state_d = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        cmd_o.chk = 1'b1;
        if (sts_i.chk_err != mbrtu_pkg::ST_OK) begin
          cmd_o.err_vld = 1'b1;
          cmd_o.err_code = sts_i.chk_err;
          state_d = S_IDLE;
        end else begin
          state_d = S_SRD;
        end
      end
      S_SRD: begin
        if (!sts_i.srch_open) begin
          cmd_o.err_vld = 1'b1;
          cmd_o.err_code = mbrtu_pkg::ST_BAD_ADDR;
          state_d = S_IDLE;
        end else begin
          cmd_o.srch_rd = 1'b1;
          state_d = S_SCMP;
        end
      end
      S_SCMP: begin
        if (sts_i.srch_eq) begin
          cmd_o.srch_hit = 1'b1;
          state_d = S_RANGE;
        end else begin
          cmd_o.srch_lt = sts_i.srch_lt;
          cmd_o.srch_gt = !sts_i.srch_lt;
          state_d = S_SRD;
        end
      end
      S_RANGE: begin
        if (sts_i.range_err != mbrtu_pkg::ST_OK) begin
          cmd_o.err_vld = 1'b1;
          cmd_o.err_code = sts_i.range_err;
          state_d = S_IDLE;
        end else begin
          cmd_o.walk_init = 1'b1;
          cmd_o.crc_init = 1'b1;
          pass_d = 1'b0;
          state_d = S_HDR;
        end
      end
      S_HDR: begin
        cmd_o.push = 1'b1;
        cmd_o.src = mbrtu_pkg::SRC_HDR;
        if (sts_i.hdr_done) state_d = S_WRD;
      end
      S_WRD: begin
        if (sts_i.i_done) begin
          state_d = S_TAIL;
        end else begin
          cmd_o.rd_ix = 1'b1;
          state_d = S_WCHK;
        end
      end
      S_WCHK: begin
        if (!sts_i.addr_ok) begin
          cmd_o.err_vld = 1'b1;
          cmd_o.err_code = mbrtu_pkg::ST_BAD_ADDR;
          state_d = S_IDLE;
        end else if (sts_i.is_short) begin
          cmd_o.load_sh = 1'b1;
          state_d = S_WBYT;
        end else if (sts_i.is_long) begin
          if (sts_i.last_pos) begin
            cmd_o.err_vld = 1'b1;
            cmd_o.err_code = mbrtu_pkg::ST_BAD_ADDR;
            state_d = S_IDLE;
          end else begin
            cmd_o.load_sh = 1'b1;
            cmd_o.rd_next = 1'b1;
            state_d = S_WCHK2;
          end
        end else begin
          cmd_o.err_vld = 1'b1;
          cmd_o.err_code = mbrtu_pkg::ST_BAD_VALUE;
          state_d = S_IDLE;
        end
      end
      S_WCHK2: begin
        if (!sts_i.next_ok) begin
          cmd_o.err_vld = 1'b1;
          cmd_o.err_code = mbrtu_pkg::ST_BAD_ADDR;
          state_d = S_IDLE;
        end else begin
          state_d = S_WBYT;
        end
      end
      S_WBYT: begin
        cmd_o.push = 1'b1;
        cmd_o.src = mbrtu_pkg::SRC_SH;
        if (sts_i.sh_last) begin
          cmd_o.step_i = 1'b1;
          state_d = S_WRD;
        end
      end
      S_TAIL: begin
        if (!pass_q) begin
          cmd_o.walk_init = 1'b1;
          pass_d = 1'b1;
          state_d = S_HDR;
        end else begin
          cmd_o.push = 1'b1;
          cmd_o.src = mbrtu_pkg::SRC_CRCLO;
          state_d = S_CRCHI;
        end
      end
      S_CRCHI: begin
        cmd_o.push = 1'b1;
        cmd_o.src = mbrtu_pkg::SRC_CRCHI;
        cmd_o.push_final = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pass_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pass_q <= pass_d;
    end
  end

endmodule

FILE: rtl/mbrtu_dp.sv
// Datapath: config registers, request store, CRC, register table memory,
// search and walk counters, word packer and result registers. Uses mbrtu_pkg.
module mbrtu_dp (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [8:0]                cfg_data_i,
  input  logic [7:0]                frame_byte_i,
  input  logic [7:0]                entry_index_i,
  input  logic [15:0]               entry_address_i,
  input  logic [2:0]                entry_type_i,
  input  logic [31:0]               entry_value_i,
  input  mbrtu_pkg::cmd_t           cmd_i,
  output mbrtu_pkg::sts_t           sts_o,
  output logic                      done_o,
  output logic [2:0]                status_o,
  output logic [31:0]               out_bytes_o,
  output logic [2:0]                byte_count_o,
  output logic                      out_last_o
);

  localparam int AW = mbrtu_pkg::TAB_AW;
  localparam int NW = mbrtu_pkg::CNT_W;

  logic [7:0]  dev_q;
  logic [8:0]  ecnt_q, cap_q;
  logic [7:0]  store_q [mbrtu_pkg::STORE_DEPTH];
  logic [8:0]  len_q;
  logic [15:0] rxcrc_q, rcrc_q;
  logic [50:0] tab_q [mbrtu_pkg::TABLE_DEPTH];
  logic [50:0] rdata_q;
  logic [NW-1:0] lo_q, hp1_q, n_cnt;
  logic [AW-1:0] mid, start_q, ix, ixn;
  logic [6:0]  i_q, step_q;
  logic [1:0]  hdr_q, pk_cnt_q;
  logic [31:0] sh_q, pk_q, pk_word;
  logic [2:0]  nb_q;
  logic [15:0] addr, qty, want;
  logic [15:0] rd_addr;
  logic [2:0]  rd_type;
  logic [7:0]  pbyte;
  logic        rd_en;
  logic [AW-1:0] rd_ix;
  logic [NW-1:0] diff;
  logic [15:0] ixw;
  mbrtu_pkg::stat_e chk_err, range_err;

  // decode request fields and table entry
  assign addr = {store_q[2], store_q[3]};
  assign qty = {store_q[4], store_q[5]};
  assign n_cnt = (ecnt_q > 9'(mbrtu_pkg::TABLE_DEPTH)) ? NW'(mbrtu_pkg::TABLE_DEPTH)
                                                        : NW'(ecnt_q);
  assign rd_addr = rdata_q[50:35];
  assign rd_type = rdata_q[34:32];
  assign diff = hp1_q - NW'(1) - lo_q;
  assign mid = AW'(lo_q + (diff >> 1));
  assign ixw = 16'(start_q) + 16'(i_q);
  assign ix = AW'(ixw);
  assign ixn = AW'(ixw + 16'd1);
  assign want = addr + 16'(i_q);

  // frame checks in order
  always_comb begin
    if (cap_q == 9'd0 || len_q > cap_q) chk_err = mbrtu_pkg::ST_BAD_VALUE;
    else if (len_q < 9'd4) chk_err = mbrtu_pkg::ST_BAD_VALUE;
    else if (store_q[0] != dev_q) chk_err = mbrtu_pkg::ST_ADDR_MISMATCH;
    else if (store_q[1] != mbrtu_pkg::FUNC_READ_HOLDING) chk_err = mbrtu_pkg::ST_ILLEGAL_FUNC;
    else if (len_q != 9'd8) chk_err = mbrtu_pkg::ST_BAD_VALUE;
    else if (rxcrc_q != 16'h0000) chk_err = mbrtu_pkg::ST_CRC;
    else if (qty == 16'd0 || qty > 16'(mbrtu_pkg::MAX_QTY)) chk_err = mbrtu_pkg::ST_BAD_ADDR;
    else if (n_cnt == NW'(0)) chk_err = mbrtu_pkg::ST_BAD_ADDR;
    else chk_err = mbrtu_pkg::ST_OK;
  end

  always_comb begin
    if (16'(start_q) + qty > 16'(n_cnt)) range_err = mbrtu_pkg::ST_BAD_ADDR;
    else if (16'd5 + {qty[14:0], 1'b0} > 16'(cap_q)) range_err = mbrtu_pkg::ST_DEV_FAIL;
    else range_err = mbrtu_pkg::ST_OK;
  end

  always_comb begin
    sts_o.chk_err = chk_err;
    sts_o.srch_open = lo_q < hp1_q;
    sts_o.srch_eq = rd_addr == addr;
    sts_o.srch_lt = rd_addr < addr;
    sts_o.range_err = range_err;
    sts_o.hdr_done = hdr_q == 2'd2;
    sts_o.i_done = 16'(i_q) >= qty;
    sts_o.addr_ok = rd_addr == want;
    sts_o.is_short = rd_type == 3'd0 || rd_type == 3'd1;
    sts_o.is_long = rd_type == 3'd2 || rd_type == 3'd3 || rd_type == 3'd4;
    sts_o.last_pos = 16'(i_q) + 16'd1 >= qty;
    sts_o.next_ok = rd_addr == want + 16'd1;
    sts_o.sh_last = nb_q == 3'd1;
  end

  // select the response byte being pushed
  always_comb begin
    case (cmd_i.src)
      mbrtu_pkg::SRC_HDR: begin
        case (hdr_q)
          2'd0: pbyte = dev_q;
          2'd1: pbyte = mbrtu_pkg::FUNC_READ_HOLDING;
          default: pbyte = {qty[6:0], 1'b0};
        endcase
      end
      mbrtu_pkg::SRC_SH: pbyte = sh_q[31:24];
      mbrtu_pkg::SRC_CRCLO: pbyte = rcrc_q[7:0];
      default: pbyte = rcrc_q[15:8];
    endcase
  end

  // merge the byte into the packer word
  always_comb begin
    pk_word = pk_q;
    case (pk_cnt_q)
      2'd0: pk_word[31:24] = pbyte;
      2'd1: pk_word[23:16] = pbyte;
      2'd2: pk_word[15:8] = pbyte;
      default: pk_word[7:0] = pbyte;
    endcase
  end

  // pick the table read address
  always_comb begin
    rd_en = cmd_i.srch_rd | cmd_i.rd_ix | cmd_i.rd_next;
    if (cmd_i.srch_rd) rd_ix = mid;
    else if (cmd_i.rd_next) rd_ix = ixn;
    else rd_ix = ix;
  end

  // table memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.tab_wr && 32'(entry_index_i) < mbrtu_pkg::TABLE_DEPTH) begin
      tab_q[AW'(entry_index_i)] <= {entry_address_i, entry_type_i, entry_value_i};
    end
    if (rd_en) rdata_q <= tab_q[rd_ix];
  end

  // request store, no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.rx_byte && len_q < 9'(mbrtu_pkg::STORE_DEPTH)) begin
      store_q[len_q[2:0]] <= frame_byte_i;
    end
  end

  // walk payload: value shifter
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_sh) begin
      sh_q <= sts_o.is_short ? {rdata_q[15:0], 16'h0000} : rdata_q[31:0];
    end else if (cmd_i.push && cmd_i.src == mbrtu_pkg::SRC_SH) begin
      sh_q <= {sh_q[23:0], 8'h00};
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_q <= 8'd1;
      ecnt_q <= 9'd0;
      cap_q <= 9'd256;
      len_q <= 9'd0;
      rxcrc_q <= mbrtu_pkg::CRC_INIT;
      rcrc_q <= mbrtu_pkg::CRC_INIT;
      lo_q <= '0;
      hp1_q <= '0;
      start_q <= '0;
      i_q <= '0;
      step_q <= '0;
      hdr_q <= '0;
      nb_q <= '0;
      pk_q <= '0;
      pk_cnt_q <= '0;
      done_o <= 1'b0;
      status_o <= '0;
      out_bytes_o <= '0;
      byte_count_o <= '0;
      out_last_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          mbrtu_pkg::CFG_DEV_ADDR: dev_q <= cfg_data_i[7:0];
          mbrtu_pkg::CFG_ENTRY_CNT: ecnt_q <= cfg_data_i;
          mbrtu_pkg::CFG_BUF_CAP: cap_q <= cfg_data_i;
          default: ;
        endcase
      end
      // receive a request byte
      if (cmd_i.rx_byte) begin
        if (len_q < 9'(mbrtu_pkg::LEN_LIMIT)) len_q <= len_q + 9'd1;
        rxcrc_q <= mbrtu_pkg::crc_byte(rxcrc_q, frame_byte_i);
      end
      // end of frame: reset reception, open the search
      if (cmd_i.chk) begin
        len_q <= 9'd0;
        rxcrc_q <= mbrtu_pkg::CRC_INIT;
        lo_q <= '0;
        hp1_q <= n_cnt;
      end
      if (cmd_i.srch_lt) lo_q <= NW'(mid) + NW'(1);
      if (cmd_i.srch_gt) hp1_q <= NW'(mid);
      if (cmd_i.srch_hit) start_q <= mid;
      if (cmd_i.walk_init) begin
        i_q <= '0;
        hdr_q <= '0;
        pk_q <= '0;
        pk_cnt_q <= '0;
      end
      if (cmd_i.crc_init) rcrc_q <= mbrtu_pkg::CRC_INIT;
      if (cmd_i.load_sh) begin
        nb_q <= sts_o.is_short ? 3'd2 : 3'd4;
        step_q <= sts_o.is_short ? 7'd1 : 7'd2;
      end
      if (cmd_i.step_i) i_q <= i_q + step_q;
      // push one response byte into the CRC or the packer
      if (cmd_i.push) begin
        if (cmd_i.src == mbrtu_pkg::SRC_HDR) hdr_q <= hdr_q + 2'd1;
        if (cmd_i.src == mbrtu_pkg::SRC_SH) nb_q <= nb_q - 3'd1;
        if (!cmd_i.sink_out) begin
          rcrc_q <= mbrtu_pkg::crc_byte(rcrc_q, pbyte);
        end else if (pk_cnt_q == 2'd3 || cmd_i.push_final) begin
          done_o <= 1'b1;
          status_o <= mbrtu_pkg::ST_OK;
          out_bytes_o <= pk_word;
          byte_count_o <= 3'(pk_cnt_q) + 3'd1;
          out_last_o <= cmd_i.push_final;
          pk_q <= '0;
          pk_cnt_q <= '0;
        end else begin
          pk_q <= pk_word;
          pk_cnt_q <= pk_cnt_q + 2'd1;
        end
      end
      // single status item for an error
      if (cmd_i.err_vld) begin
        done_o <= 1'b1;
        status_o <= cmd_i.err_code;
        out_bytes_o <= '0;
        byte_count_o <= '0;
        out_last_o <= 1'b1;
      end
    end
  end

endmodule

FILE: rtl/modbus_rtu_read_holding_responder.sv
// Top level of the Modbus RTU read-holding-registers responder.
// Instantiates mbrtu_ctrl and mbrtu_dp; uses mbrtu_pkg.
//
// Usage: drive start_i with one item; it transfers when start_i is high and
// busy_o is low. command_i = 0 carries a request byte (frame_last_i marks
// the last one), command_i = 1 writes one register table entry. Byte and
// entry transfers leave busy_o low, so they can come every cycle. After the
// last byte busy_o rises and the block checks the frame, binary-searches
// the table (up to 9 probes for 256 entries, one table read port), then
// walks the response twice through the same read port: once for the checks
// and the CRC, once to emit. Each pass pushes the header bytes, then reads
// each entry, checks it and pushes its data bytes. Results appear for one
// cycle with done_o; the receiver cannot stall and must take them. An error
// gives one item with a nonzero status_o and no frame. busy_o falls as the
// last item shows. Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i)
// take effect at once; the user must make them only while idle, as the
// block does not enforce this. Reset restores the register defaults and
// clears reception; the table stays undefined until written.
module modbus_rtu_read_holding_responder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [8:0]  cfg_data_i,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        command_i,
  input  logic [7:0]  frame_byte_i,
  input  logic        frame_last_i,
  input  logic [7:0]  entry_index_i,
  input  logic [15:0] entry_address_i,
  input  logic [2:0]  entry_type_i,
  input  logic [31:0] entry_value_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [31:0] out_bytes_o,
  output logic [2:0]  byte_count_o,
  output logic        out_last_o
);

  mbrtu_pkg::cmd_t cmd;
  mbrtu_pkg::sts_t sts;

  mbrtu_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .command_i    (command_i),
    .frame_last_i (frame_last_i),
    .sts_i        (sts),
    .cmd_o        (cmd),
    .busy_o       (busy_o)
  );

  mbrtu_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .frame_byte_i    (frame_byte_i),
    .entry_index_i   (entry_index_i),
    .entry_address_i (entry_address_i),
    .entry_type_i    (entry_type_i),
    .entry_value_i   (entry_value_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .done_o          (done_o),
    .status_o        (status_o),
    .out_bytes_o     (out_bytes_o),
    .byte_count_o    (byte_count_o),
    .out_last_o      (out_last_o)
  );

  // final item returns the block to idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && out_last_o |-> !busy_o) else $error("busy after final item");

  // intermediate items are full words while still busy
  a_mid_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !out_last_o |-> busy_o && byte_count_o == 3'd4 && status_o == 3'd0)
    else $error("partial word before final item");

  // an error item carries no bytes
  a_err_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != 3'd0 |-> byte_count_o == 3'd0 && out_last_o)
    else $error("error item with bytes");

  // a good frame item carries bytes
  a_ok_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o == 3'd0 |-> byte_count_o != 3'd0)
    else $error("empty frame item");

endmodule
